FILE: rtl/hsv2rgb_pkg.sv
package hsv2rgb_pkg;

  localparam int unsigned HUE_W  = 11;
  localparam int unsigned FRAC_W = 8;
  localparam int unsigned PORT_W = 8;

  typedef enum logic [2:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYN = 3'd2,
    SEC_CYN_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } sector_e;

  typedef struct packed {
    logic    valid;
    sector_e sector;
  } stage_ctl_t;

  // hue sector wraps modulo six
  function automatic sector_e sector_of(input logic [2:0] code);
    sector_e sec;
    case (code)
      3'd0:    sec = SEC_RED_YEL;
      3'd1:    sec = SEC_YEL_GRN;
      3'd2:    sec = SEC_GRN_CYN;
      3'd3:    sec = SEC_CYN_BLU;
      3'd4:    sec = SEC_BLU_MAG;
      3'd5:    sec = SEC_MAG_RED;
      3'd6:    sec = SEC_RED_YEL;
      default: sec = SEC_YEL_GRN;
    endcase
    return sec;
  endfunction

endpackage

FILE: rtl/hsv2rgb_prep.sv
module hsv2rgb_prep #(
  parameter int unsigned COMPONENT_BITS = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [hsv2rgb_pkg::HUE_W-1:0]       hue_i,
  input  logic [hsv2rgb_pkg::PORT_W-1:0]      saturation_i,
  input  logic [hsv2rgb_pkg::PORT_W-1:0]      brightness_i,
  output hsv2rgb_pkg::stage_ctl_t             ctl_o,
  output logic [COMPONENT_BITS-1:0]           v_o,
  output logic [COMPONENT_BITS-1:0]           ms_o,
  output logic [COMPONENT_BITS+hsv2rgb_pkg::FRAC_W-1:0] qk_o,
  output logic [COMPONENT_BITS+hsv2rgb_pkg::FRAC_W-1:0] tk_o
);

  localparam int unsigned CB = COMPONENT_BITS;
  localparam int unsigned KW = CB + hsv2rgb_pkg::FRAC_W;
  localparam int unsigned EW = CB + hsv2rgb_pkg::PORT_W;
  localparam logic [CB-1:0] Max = CB'((1 << CB) - 1);
  localparam logic [KW-1:0] Full = KW'(Max) << hsv2rgb_pkg::FRAC_W;

  logic [EW-1:0] sat_ext, bri_ext;
  logic [CB-1:0] s, v;
  logic [hsv2rgb_pkg::FRAC_W-1:0] f;
  logic [KW-1:0] fs;

  hsv2rgb_pkg::stage_ctl_t ctl_d, ctl_q;
  logic [CB-1:0] v_q, ms_d, ms_q;
  logic [KW-1:0] qk_d, qk_q, tk_d, tk_q;

  // inputs are taken in their low component bits
  assign sat_ext = EW'(saturation_i);
  assign bri_ext = EW'(brightness_i);
  assign s       = sat_ext[CB-1:0];
  assign v       = bri_ext[CB-1:0];
  assign f       = hue_i[hsv2rgb_pkg::FRAC_W-1:0];

  assign fs   = KW'(f) * KW'(s);
  assign ms_d = Max - s;
  assign qk_d = Full - fs;
  // 256 * M - (256 - f) * s folded as 256 * (M - s) + f * s
  assign tk_d = (KW'(ms_d) << hsv2rgb_pkg::FRAC_W) + fs;

  assign ctl_d.valid  = start_i;
  assign ctl_d.sector = hsv2rgb_pkg::sector_of(hue_i[hsv2rgb_pkg::HUE_W-1:hsv2rgb_pkg::FRAC_W]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q          <= v;
    ms_q         <= ms_d;
    qk_q         <= qk_d;
    tk_q         <= tk_d;
  end

  assign ctl_o = ctl_q;
  assign v_o   = v_q;
  assign ms_o  = ms_q;
  assign qk_o  = qk_q;
  assign tk_o  = tk_q;

endmodule

FILE: rtl/hsv2rgb_mul.sv
module hsv2rgb_mul #(
  parameter int unsigned COMPONENT_BITS = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  hsv2rgb_pkg::stage_ctl_t             ctl_i,
  input  logic [COMPONENT_BITS-1:0]           v_i,
  input  logic [COMPONENT_BITS-1:0]           ms_i,
  input  logic [COMPONENT_BITS+hsv2rgb_pkg::FRAC_W-1:0] qk_i,
  input  logic [COMPONENT_BITS+hsv2rgb_pkg::FRAC_W-1:0] tk_i,
  output hsv2rgb_pkg::stage_ctl_t             ctl_o,
  output logic [COMPONENT_BITS-1:0]           v_o,
  output logic [2*COMPONENT_BITS-1:0]         np_o,
  output logic [2*COMPONENT_BITS-1:0]         nq_o,
  output logic [2*COMPONENT_BITS-1:0]         nt_o
);

  localparam int unsigned CB = COMPONENT_BITS;
  localparam int unsigned NW = 2 * CB;
  localparam int unsigned WW = NW + hsv2rgb_pkg::FRAC_W;
  localparam int unsigned Max = (1 << CB) - 1;
  localparam logic [NW-1:0] HalfMax  = NW'(Max / 2);
  // half of 256 * M, the rounding term for the sector fractions
  localparam logic [WW-1:0] HalfFull = WW'(Max) << (hsv2rgb_pkg::FRAC_W - 1);

  // stage two: products
  hsv2rgb_pkg::stage_ctl_t ctl2_q, ctl3_q;
  logic [CB-1:0] v2_q, v3_q;
  logic [NW-1:0] pm_d, pm_q;
  logic [WW-1:0] qm_d, qm_q, tm_d, tm_q;

  // stage three: rounded numerators over M
  logic [NW-1:0] np_d, np_q, nq_d, nq_q, nt_d, nt_q;
  logic [WW-1:0] qsum, tsum;

  assign pm_d = NW'(v_i) * NW'(ms_i);
  assign qm_d = WW'(v_i) * WW'(qk_i);
  assign tm_d = WW'(v_i) * WW'(tk_i);

  assign np_d = pm_q + HalfMax;
  assign qsum = qm_q + HalfFull;
  assign tsum = tm_q + HalfFull;
  assign nq_d = qsum[WW-1:hsv2rgb_pkg::FRAC_W];
  assign nt_d = tsum[WW-1:hsv2rgb_pkg::FRAC_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl2_q <= '0;
      ctl3_q <= '0;
    end else begin
      ctl2_q <= ctl_i;
      ctl3_q <= ctl2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    v2_q          <= v_i;
    pm_q          <= pm_d;
    qm_q          <= qm_d;
    tm_q          <= tm_d;
    v3_q          <= v2_q;
    np_q          <= np_d;
    nq_q          <= nq_d;
    nt_q          <= nt_d;
  end

  assign ctl_o = ctl3_q;
  assign v_o   = v3_q;
  assign np_o  = np_q;
  assign nq_o  = nq_q;
  assign nt_o  = nt_q;

endmodule

FILE: rtl/hsv2rgb_div.sv
module hsv2rgb_div #(
  parameter int unsigned COMPONENT_BITS = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  hsv2rgb_pkg::stage_ctl_t         ctl_i,
  input  logic [COMPONENT_BITS-1:0]       v_i,
  input  logic [2*COMPONENT_BITS-1:0]     np_i,
  input  logic [2*COMPONENT_BITS-1:0]     nq_i,
  input  logic [2*COMPONENT_BITS-1:0]     nt_i,
  output logic                            valid_o,
  output logic [hsv2rgb_pkg::PORT_W-1:0]  red_o,
  output logic [hsv2rgb_pkg::PORT_W-1:0]  green_o,
  output logic [hsv2rgb_pkg::PORT_W-1:0]  blue_o
);

  localparam int unsigned CB = COMPONENT_BITS;
  localparam int unsigned NW = 2 * CB;
  localparam int unsigned EW = CB + hsv2rgb_pkg::PORT_W;

  // floor(n / (2^CB - 1)) for n below (2^CB - 1) * 2^CB
  function automatic logic [CB-1:0] div_max(input logic [NW-1:0] n);
    logic [NW:0] acc;
    acc = {1'b0, n} + (NW+1)'(n >> CB) + (NW+1)'(1);
    return acc[NW-1:CB];
  endfunction

  logic [CB-1:0] p, q, t, r_d, g_d, b_d;
  logic [EW-1:0] r_ext, g_ext, b_ext;
  logic valid_q;
  logic [hsv2rgb_pkg::PORT_W-1:0] red_q, green_q, blue_q;

  assign p = div_max(np_i);
  assign q = div_max(nq_i);
  assign t = div_max(nt_i);

  always_comb begin
    case (ctl_i.sector)
      hsv2rgb_pkg::SEC_RED_YEL: begin r_d = v_i; g_d = t;   b_d = p;   end
      hsv2rgb_pkg::SEC_YEL_GRN: begin r_d = q;   g_d = v_i; b_d = p;   end
      hsv2rgb_pkg::SEC_GRN_CYN: begin r_d = p;   g_d = v_i; b_d = t;   end
      hsv2rgb_pkg::SEC_CYN_BLU: begin r_d = p;   g_d = q;   b_d = v_i; end
      hsv2rgb_pkg::SEC_BLU_MAG: begin r_d = t;   g_d = p;   b_d = v_i; end
      default:                  begin r_d = v_i; g_d = p;   b_d = q;   end
    endcase
  end

  assign r_ext = EW'(r_d);
  assign g_ext = EW'(g_d);
  assign b_ext = EW'(b_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    red_q   <= r_ext[hsv2rgb_pkg::PORT_W-1:0];
    green_q <= g_ext[hsv2rgb_pkg::PORT_W-1:0];
    blue_q  <= b_ext[hsv2rgb_pkg::PORT_W-1:0];
  end

  assign valid_o = valid_q;
  assign red_o   = red_q;
  assign green_o = green_q;
  assign blue_o  = blue_q;

endmodule

FILE: rtl/hsv_to_rgb.sv
// HSV to RGB pixel converter. One pixel is taken in every clock cycle (busy is
// always low); its red, green and blue come out on a single-cycle valid_o
// strobe; the receiver cannot stall, so each result must be caught in the
// cycle it appears. There are four register stages: sector decode and f*s,
// the three v products, rounding, and the division by full scale with sector
// routing. Hue carries 256 steps per 60-degree sector in its low 8 bits;
// sectors six and seven wrap to zero and one.
module hsv_to_rgb #(
  parameter int unsigned COMPONENT_BITS = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [hsv2rgb_pkg::HUE_W-1:0]       hue_i,
  input  logic [hsv2rgb_pkg::PORT_W-1:0]      saturation_i,
  input  logic [hsv2rgb_pkg::PORT_W-1:0]      brightness_i,
  output logic                                valid_o,
  output logic [hsv2rgb_pkg::PORT_W-1:0]      red_o,
  output logic [hsv2rgb_pkg::PORT_W-1:0]      green_o,
  output logic [hsv2rgb_pkg::PORT_W-1:0]      blue_o
);

  localparam int unsigned CB = COMPONENT_BITS;
  localparam int unsigned KW = CB + hsv2rgb_pkg::FRAC_W;

  hsv2rgb_pkg::stage_ctl_t ctl1, ctl3;
  logic [CB-1:0] v1, v3, ms1;
  logic [KW-1:0] qk1, tk1;
  logic [2*CB-1:0] np3, nq3, nt3;

  assign busy = 1'b0;

  hsv2rgb_prep #(.COMPONENT_BITS(CB)) u_prep (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .hue_i        (hue_i),
    .saturation_i (saturation_i),
    .brightness_i (brightness_i),
    .ctl_o        (ctl1),
    .v_o          (v1),
    .ms_o         (ms1),
    .qk_o         (qk1),
    .tk_o         (tk1)
  );

  hsv2rgb_mul #(.COMPONENT_BITS(CB)) u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl1),
    .v_i    (v1),
    .ms_i   (ms1),
    .qk_i   (qk1),
    .tk_i   (tk1),
    .ctl_o  (ctl3),
    .v_o    (v3),
    .np_o   (np3),
    .nq_o   (nq3),
    .nt_o   (nt3)
  );

  hsv2rgb_div #(.COMPONENT_BITS(CB)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl3),
    .v_i     (v3),
    .np_i    (np3),
    .nq_i    (nq3),
    .nt_i    (nt3),
    .valid_o (valid_o),
    .red_o   (red_o),
    .green_o (green_o),
    .blue_o  (blue_o)
  );

  // every transaction yields a result strobe
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |-> ##4 valid_o)
    else $error("result strobe missing four cycles after a transaction");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start, 4))
    else $error("result strobe without a transaction");

  // no component may exceed the value input
  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |-> ##4 ((red_o <= $past(brightness_i, 4)) && (green_o <= $past(brightness_i, 4))
                   && (blue_o <= $past(brightness_i, 4))))
    else $error("component above value");

  // zero saturation gives a gray pixel
  a_gray: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && (saturation_i == '0)) |-> ##4 ((red_o == green_o) && (green_o == blue_o)))
    else $error("gray pixel not gray");

endmodule

FILE: tb/hsv_to_rgb_tb.sv
`timescale 1ns / 100ps

module hsv_to_rgb_tb;

  typedef struct packed {
    logic [hsv2rgb_pkg::PORT_W-1:0] red;
    logic [hsv2rgb_pkg::PORT_W-1:0] green;
    logic [hsv2rgb_pkg::PORT_W-1:0] blue;
  } rgb_t;

  // typed-in expectation that travels with each driven pixel
  typedef struct packed {
    logic known;
    rgb_t color;
  } pixel_note_t;

  typedef struct packed {
    logic [hsv2rgb_pkg::HUE_W-1:0]  hue;
    logic [hsv2rgb_pkg::PORT_W-1:0] sat;
    logic [hsv2rgb_pkg::PORT_W-1:0] val;
    logic                           known;
    rgb_t                           color;
  } hsv_row_t;

  localparam int unsigned FULL_SCALE = 255;
  localparam int unsigned NUM_ROWS   = 20;
  localparam int unsigned PHASE_ITEMS = 317;

  localparam hsv_row_t HSV_ROWS [NUM_ROWS] = '{
    '{11'd0,    8'd255, 8'd255, 1'b1, '{8'd255, 8'd0,   8'd0}},
    '{11'd256,  8'd255, 8'd255, 1'b1, '{8'd255, 8'd255, 8'd0}},
    '{11'd512,  8'd255, 8'd255, 1'b1, '{8'd0,   8'd255, 8'd0}},
    '{11'd768,  8'd255, 8'd255, 1'b1, '{8'd0,   8'd255, 8'd255}},
    '{11'd1024, 8'd255, 8'd255, 1'b1, '{8'd0,   8'd0,   8'd255}},
    '{11'd1280, 8'd255, 8'd255, 1'b1, '{8'd255, 8'd0,   8'd255}},
    '{11'd1536, 8'd255, 8'd255, 1'b1, '{8'd255, 8'd0,   8'd0}},
    '{11'd1792, 8'd255, 8'd255, 1'b1, '{8'd255, 8'd255, 8'd0}},
    '{11'd2047, 8'd255, 8'd255, 1'b0, '{8'd0,   8'd0,   8'd0}},
    '{11'd0,    8'd0,   8'd0,   1'b1, '{8'd0,   8'd0,   8'd0}},
    '{11'd2047, 8'd0,   8'd255, 1'b1, '{8'd255, 8'd255, 8'd255}},
    '{11'd1000, 8'd0,   8'd128, 1'b1, '{8'd128, 8'd128, 8'd128}},
    '{11'd1535, 8'd255, 8'd255, 1'b0, '{8'd0,   8'd0,   8'd0}},
    '{11'd255,  8'd255, 8'd255, 1'b0, '{8'd0,   8'd0,   8'd0}},
    '{11'd128,  8'd128, 8'd200, 1'b0, '{8'd0,   8'd0,   8'd0}},
    '{11'd1663, 8'd200, 8'd100, 1'b0, '{8'd0,   8'd0,   8'd0}},
    '{11'd900,  8'd255, 8'd0,   1'b1, '{8'd0,   8'd0,   8'd0}},
    '{11'd1920, 8'd1,   8'd1,   1'b0, '{8'd0,   8'd0,   8'd0}},
    '{11'd383,  8'd170, 8'd85,  1'b0, '{8'd0,   8'd0,   8'd0}},
    '{11'd1200, 8'd255, 8'd1,   1'b0, '{8'd0,   8'd0,   8'd0}}
  };

  logic                           clk_i        = 1'b0;
  logic                           rst_ni       = 1'b0;
  logic                           start        = 1'b0;
  logic [hsv2rgb_pkg::HUE_W-1:0]  hue_i        = '0;
  logic [hsv2rgb_pkg::PORT_W-1:0] saturation_i = '0;
  logic [hsv2rgb_pkg::PORT_W-1:0] brightness_i = '0;
  logic                           busy;
  logic                           valid_o;
  logic [hsv2rgb_pkg::PORT_W-1:0] red_o;
  logic [hsv2rgb_pkg::PORT_W-1:0] green_o;
  logic [hsv2rgb_pkg::PORT_W-1:0] blue_o;

  rgb_t        rgb_expect_q [$];
  pixel_note_t pixel_note_q [$];
  int unsigned mismatch_count = 0;

  hsv_to_rgb u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .hue_i        (hue_i),
    .saturation_i (saturation_i),
    .brightness_i (brightness_i),
    .valid_o      (valid_o),
    .red_o        (red_o),
    .green_o      (green_o),
    .blue_o       (blue_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic rgb_t hsv_predict(logic [hsv2rgb_pkg::HUE_W-1:0] hue,
                                       logic [hsv2rgb_pkg::PORT_W-1:0] sat,
                                       logic [hsv2rgb_pkg::PORT_W-1:0] val);
    int unsigned          s_w;
    int unsigned          v_w;
    int unsigned          frac;
    int unsigned          span;
    int unsigned          p_lvl;
    int unsigned          q_lvl;
    int unsigned          t_lvl;
    int unsigned          sec_idx;
    hsv2rgb_pkg::sector_e sec;
    rgb_t                 color;
    s_w     = sat;
    v_w     = val;
    frac    = hue[hsv2rgb_pkg::FRAC_W-1:0];
    span    = 256 * FULL_SCALE;
    p_lvl   = (v_w * (FULL_SCALE - s_w) + FULL_SCALE / 2) / FULL_SCALE;
    q_lvl   = (v_w * (span - frac * s_w) + span / 2) / span;
    t_lvl   = (v_w * (span - (256 - frac) * s_w) + span / 2) / span;
    // sectors six and seven wrap around the circle
    sec_idx = hue[hsv2rgb_pkg::HUE_W-1:hsv2rgb_pkg::FRAC_W] % 6;
    sec     = hsv2rgb_pkg::sector_e'(sec_idx[2:0]);
    case (sec)
      hsv2rgb_pkg::SEC_RED_YEL: color = '{val, t_lvl[7:0], p_lvl[7:0]};
      hsv2rgb_pkg::SEC_YEL_GRN: color = '{q_lvl[7:0], val, p_lvl[7:0]};
      hsv2rgb_pkg::SEC_GRN_CYN: color = '{p_lvl[7:0], val, t_lvl[7:0]};
      hsv2rgb_pkg::SEC_CYN_BLU: color = '{p_lvl[7:0], q_lvl[7:0], val};
      hsv2rgb_pkg::SEC_BLU_MAG: color = '{t_lvl[7:0], p_lvl[7:0], val};
      default:                  color = '{val, p_lvl[7:0], q_lvl[7:0]};
    endcase
    return color;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic compare_field(input string field, input logic [7:0] got,
                               input logic [7:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s mismatch: got %0d expected %0d", field, got, want));
    end
  endtask

  // scoreboard: sample both sides at the clock edge
  always @(posedge clk_i) begin
    rgb_t        want;
    pixel_note_t note;
    if (rst_ni) begin
      if (valid_o) begin
        if (rgb_expect_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result %0d %0d %0d",
                                    red_o, green_o, blue_o));
        end else begin
          want = rgb_expect_q.pop_front();
          compare_field("red", red_o, want.red);
          compare_field("green", green_o, want.green);
          compare_field("blue", blue_o, want.blue);
        end
      end
      if (start && !busy) begin
        note = pixel_note_q.pop_front();
        if (note.known) begin
          rgb_expect_q.push_back(note.color);
        end else begin
          rgb_expect_q.push_back(hsv_predict(hue_i, saturation_i, brightness_i));
        end
      end
    end
  end

  task automatic send_pixel(input logic [hsv2rgb_pkg::HUE_W-1:0] hue,
                            input logic [hsv2rgb_pkg::PORT_W-1:0] sat,
                            input logic [hsv2rgb_pkg::PORT_W-1:0] val,
                            input pixel_note_t note,
                            input int unsigned idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start        <= 1'b1;
    hue_i        <= hue;
    saturation_i <= sat;
    brightness_i <= val;
    pixel_note_q.push_back(note);
    @(posedge clk_i);
    while (busy) begin
      @(posedge clk_i);
    end
  endtask

  task automatic wait_drained(input int unsigned max_cycles);
    int unsigned waited;
    waited = 0;
    start <= 1'b0;
    @(posedge clk_i);
    while (rgb_expect_q.size() != 0 && waited < max_cycles) begin
      @(posedge clk_i);
      waited++;
    end
  endtask

  function automatic logic [7:0] pick_level();
    case ($urandom_range(7))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  initial begin
    pixel_note_t       note;
    int unsigned       idle_pct;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (HSV_ROWS[i]) begin
      note = '{HSV_ROWS[i].known, HSV_ROWS[i].color};
      send_pixel(HSV_ROWS[i].hue, HSV_ROWS[i].sat, HSV_ROWS[i].val, note, 0);
    end
    // hold off until the pipeline is empty
    wait_drained(200);

    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 19 : (phase == 1) ? 85 : 0;
      repeat (PHASE_ITEMS) begin
        note = '0;
        send_pixel(11'($urandom_range(2047)), pick_level(), pick_level(), note, idle_pct);
      end
      wait_drained(200);
    end

    repeat (8) @(posedge clk_i);
    if (rgb_expect_q.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", rgb_expect_q.size()));
    end
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #500000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
